FILE: hw/rtl/esf_pkg.sv
// shared constants, codes and types for the event subscription fan-out
package esf_pkg;

  localparam int EVENT_COUNT = 128;
  localparam int TASK_COUNT  = 32;

  localparam int EVENT_W = 8;
  localparam int TASK_W  = 5;
  localparam int HANDLE_W = 32;
  localparam int SIZE_W  = 16;
  localparam int MASK_W  = 32;
  localparam int COUNT_W = 32;
  localparam int ADDR_W  = $clog2(EVENT_COUNT);

  localparam int IN_TDATA_W  = 64;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 128;

  // usable task bits of a mask
  localparam logic [MASK_W-1:0] TASK_MASK = MASK_W'((64'd1 << TASK_COUNT) - 64'd1);

  // request actions
  localparam logic [IN_TUSER_W-1:0] ACT_SUBSCRIBE   = 2'd0;
  localparam logic [IN_TUSER_W-1:0] ACT_UNSUBSCRIBE = 2'd1;
  localparam logic [IN_TUSER_W-1:0] ACT_PUBLISH     = 2'd2;

  // result kinds
  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_DROP    = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } state_t;

endpackage

FILE: hw/rtl/esf_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module esf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/event_subscription_fanout.sv
// top level of the event subscription fan-out: mask table, sequencer and result stage
//
// channel   dir  handshake            payload
// in_*      in   in_tvalid/in_tready  in_tuser action, in_tdata request fields
// out_*     out  out_tvalid/out_tready out_tuser kind, out_tlast, out_tdata result
//
// a subscribe or unsubscribe reads the table, then modifies and writes back the mask
// a publish reads the table, then emits one drop result or one result per subscriber
// through the single result register, one delivery a cycle while out is not stalled
// the table has one valid bit per entry, so reset clears all masks at once
// a stalled result stalls only the sequencer; a new request is taken while the last
// result of the previous one still waits in the result register
module event_subscription_fanout (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [7:0] event_number, [12:8] task_index, [44:13] payload_handle,
  // [60:45] payload_size, [61] handle_once, [63:62] zero
  input  logic [esf_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [1:0] action
  input  logic [esf_pkg::IN_TUSER_W-1:0]     in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [4:0] target_task, [12:5] event_out, [44:13] handle_out, [60:45] size_out,
  // [61] copy_needed, [93:62] published_total, [125:94] dropped_total, [127:126] zero
  output logic [esf_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [0] kind
  output logic                               out_tuser,
  output logic                               out_tlast
);

  esf_pkg::state_t state_r, state_nxt;

  // captured request
  logic [esf_pkg::IN_TUSER_W-1:0] act_r;
  logic [esf_pkg::EVENT_W-1:0]    ev_r;
  logic [esf_pkg::TASK_W-1:0]     task_r;
  logic [esf_pkg::HANDLE_W-1:0]   handle_r;
  logic [esf_pkg::SIZE_W-1:0]     size_r;
  logic                           zc_r;

  logic [esf_pkg::MASK_W-1:0]     mask_r, mask_nxt;
  logic                           first_r, first_nxt;
  logic [esf_pkg::COUNT_W-1:0]    dlv_cnt_r, dlv_cnt_nxt;
  logic [esf_pkg::COUNT_W-1:0]    drop_cnt_r, drop_cnt_nxt;
  logic [esf_pkg::EVENT_COUNT-1:0] valid_r;

  // result register
  logic                           out_valid_r, out_valid_nxt;
  logic                           out_kind_r;
  logic                           out_last_r;
  logic [esf_pkg::TASK_W-1:0]     out_task_r;
  logic [esf_pkg::EVENT_W-1:0]    out_ev_r;
  logic [esf_pkg::HANDLE_W-1:0]   out_handle_r;
  logic [esf_pkg::SIZE_W-1:0]     out_size_r;
  logic                           out_copy_r;
  logic [esf_pkg::COUNT_W-1:0]    out_pub_r;
  logic [esf_pkg::COUNT_W-1:0]    out_drop_r;

  // request field views
  logic [esf_pkg::EVENT_W-1:0]    in_ev;
  logic [esf_pkg::TASK_W-1:0]     in_task;
  logic                           in_acc;
  logic                           in_ok;

  // table port
  logic                           ram_we;
  logic [esf_pkg::ADDR_W-1:0]     ram_waddr;
  logic [esf_pkg::ADDR_W-1:0]     ram_raddr;
  logic [esf_pkg::MASK_W-1:0]     ram_wdata;
  logic [esf_pkg::MASK_W-1:0]     ram_rdata;
  logic [esf_pkg::MASK_W-1:0]     rd_mask;
  logic [esf_pkg::ADDR_W-1:0]     ev_addr;
  logic [esf_pkg::MASK_W-1:0]     task_bit;

  // scan helpers
  logic [esf_pkg::TASK_W-1:0]     low_idx;
  logic [esf_pkg::MASK_W-1:0]     mask_rest;
  logic                           out_load;

  assign in_ev   = in_tdata[7:0];
  assign in_task = in_tdata[12:8];
  assign in_acc  = in_tvalid && in_tready;

  // request needs the table: known action, event in range, task in range if not publish
  assign in_ok = ({1'b0, in_ev} < 9'(esf_pkg::EVENT_COUNT)) &&
                 ((in_tuser == esf_pkg::ACT_PUBLISH) ||
                  (((in_tuser == esf_pkg::ACT_SUBSCRIBE) ||
                    (in_tuser == esf_pkg::ACT_UNSUBSCRIBE)) &&
                   ({1'b0, in_task} < 6'(esf_pkg::TASK_COUNT))));

  assign in_tready = (state_r == esf_pkg::ST_IDLE);

  assign ev_addr   = ev_r[esf_pkg::ADDR_W-1:0];
  assign ram_raddr = in_ev[esf_pkg::ADDR_W-1:0];
  assign ram_waddr = ev_addr;
  assign rd_mask   = valid_r[ev_addr] ? ram_rdata : '0;
  assign task_bit  = esf_pkg::MASK_W'(1) << task_r;

  esf_ram #(
    .WIDTH(esf_pkg::MASK_W),
    .DEPTH(esf_pkg::EVENT_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // lowest subscribed task of the remaining mask
  always_comb begin
    low_idx = '0;
    for (int i = esf_pkg::MASK_W - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        low_idx = esf_pkg::TASK_W'(i);
      end
    end
  end

  assign mask_rest = mask_r & (mask_r - esf_pkg::MASK_W'(1));
  assign out_load  = (state_r == esf_pkg::ST_EMIT) && (!out_valid_r || out_tready);

  // sequencer next state and table write
  always_comb begin
    state_nxt    = state_r;
    mask_nxt     = mask_r;
    first_nxt    = first_r;
    dlv_cnt_nxt  = dlv_cnt_r;
    drop_cnt_nxt = drop_cnt_r;
    ram_we       = 1'b0;
    ram_wdata    = rd_mask;
    case (state_r)
      esf_pkg::ST_IDLE: begin
        if (in_acc && in_ok) begin
          state_nxt = esf_pkg::ST_READ;
        end
      end
      esf_pkg::ST_READ: begin
        if (act_r == esf_pkg::ACT_PUBLISH) begin
          mask_nxt  = rd_mask & esf_pkg::TASK_MASK;
          first_nxt = 1'b1;
          state_nxt = esf_pkg::ST_EMIT;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = (act_r == esf_pkg::ACT_SUBSCRIBE) ? (rd_mask | task_bit)
                                                        : (rd_mask & ~task_bit);
          state_nxt = esf_pkg::ST_IDLE;
        end
      end
      esf_pkg::ST_EMIT: begin
        if (out_load) begin
          first_nxt = 1'b0;
          if (mask_r == '0) begin
            drop_cnt_nxt = drop_cnt_r + esf_pkg::COUNT_W'(1);
            state_nxt    = esf_pkg::ST_IDLE;
          end else begin
            dlv_cnt_nxt = dlv_cnt_r + esf_pkg::COUNT_W'(1);
            mask_nxt    = mask_rest;
            if (mask_rest == '0) begin
              state_nxt = esf_pkg::ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = esf_pkg::ST_IDLE;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= esf_pkg::ST_IDLE;
      valid_r     <= '0;
      dlv_cnt_r   <= '0;
      drop_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      first_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dlv_cnt_r   <= dlv_cnt_nxt;
      drop_cnt_r  <= drop_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      first_r     <= first_nxt;
      if (ram_we) begin
        valid_r[ev_addr] <= 1'b1;
      end
    end
  end

  // request capture and scan mask
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r    <= in_tuser;
      ev_r     <= in_ev;
      task_r   <= in_task;
      handle_r <= in_tdata[44:13];
      size_r   <= in_tdata[60:45];
      zc_r     <= in_tdata[61];
    end
    mask_r <= mask_nxt;
  end

  // result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ev_r   <= ev_r;
      out_pub_r  <= dlv_cnt_nxt;
      out_drop_r <= drop_cnt_nxt;
      if (mask_r == '0) begin
        out_kind_r   <= esf_pkg::KIND_DROP;
        out_task_r   <= '0;
        out_handle_r <= '0;
        out_size_r   <= '0;
        out_copy_r   <= 1'b0;
        out_last_r   <= 1'b1;
      end else begin
        out_kind_r   <= esf_pkg::KIND_DELIVER;
        out_task_r   <= low_idx;
        out_handle_r <= (zc_r && !first_r) ? '0 : handle_r;
        out_size_r   <= size_r;
        out_copy_r   <= !zc_r;
        out_last_r   <= (mask_rest == '0);
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_drop_r, out_pub_r, out_copy_r, out_size_r,
                       out_handle_r, out_ev_r, out_task_r};

  // a drop result always closes its publish
  a_drop_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == esf_pkg::KIND_DROP)) |-> out_tlast)
    else $error("drop result without last");

  // an empty scan mask in the emit state only occurs before any delivery
  a_empty_first: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == esf_pkg::ST_EMIT) && (mask_r == '0)) |-> first_r)
    else $error("empty mask after deliveries started");

  // a table request always goes to the read state next
  a_take_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ok) |=> (state_r == esf_pkg::ST_READ))
    else $error("accepted request did not read the table");

  // the drop counter moves only with a drop result loaded
  a_drop_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (drop_cnt_r != $past(drop_cnt_r)) |-> (out_tvalid && (out_tuser == esf_pkg::KIND_DROP)))
    else $error("drop count changed without a drop result");

endmodule
